// ===== hw/rtl/vlan_rule_order_compare_macros.svh =====
// Assertion helpers used by vlan_rule_order_compare.sv.
`ifndef VLAN_RULE_ORDER_COMPARE_MACROS_SVH
`define VLAN_RULE_ORDER_COMPARE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrc assertion failed");

// Next-cycle implication, checked out of reset.
`define VRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrc assertion failed");

`endif

// ===== hw/rtl/vrc_pkg.sv =====
package vrc_pkg;

    localparam int ORDER_W  = 24;
    localparam int FILTER_W = 48;
    localparam int TREAT_W  = 42;
    localparam int TPIDS_W  = 32;

    typedef logic signed [1:0] ord_t;

    // Sort order codes
    localparam ord_t ORD_BEFORE = 2'sb11;
    localparam ord_t ORD_EQUAL  = 2'sb00;
    localparam ord_t ORD_AFTER  = 2'sb01;

    // Filter priorities that mark a default rule, and the ethertype "ignore" code
    localparam logic [3:0] PRI_15    = 4'd15;
    localparam logic [3:0] PRI_14    = 4'd14;
    localparam logic [3:0] ET_IGNORE = 4'd0;

    // TPID/DE codes, named after their binary value
    localparam logic [3:0] TDE_0010 = 4'b0010;
    localparam logic [3:0] TDE_0011 = 4'b0011;
    localparam logic [3:0] TDE_0100 = 4'b0100;
    localparam logic [3:0] TDE_0101 = 4'b0101;
    localparam logic [3:0] TDE_0110 = 4'b0110;
    localparam logic [3:0] TDE_0111 = 4'b0111;
    localparam logic [3:0] TDE_1000 = 4'b1000;
    localparam logic [3:0] TDE_1001 = 4'b1001;
    localparam logic [3:0] TDE_1010 = 4'b1010;

endpackage

// ===== hw/rtl/vrc_if.sv =====
interface vrc_rule_if;
    logic                           valid;
    logic                           ready;
    logic [vrc_pkg::ORDER_W-1:0]    a_order;
    logic [vrc_pkg::FILTER_W-1:0]   a_filter;
    logic [vrc_pkg::TREAT_W-1:0]    a_treatment;
    logic [vrc_pkg::TPIDS_W-1:0]    a_tpids;
    logic [vrc_pkg::ORDER_W-1:0]    b_order;
    logic [vrc_pkg::FILTER_W-1:0]   b_filter;
    logic [vrc_pkg::TREAT_W-1:0]    b_treatment;
    logic [vrc_pkg::TPIDS_W-1:0]    b_tpids;

    modport source (
        output valid, a_order, a_filter, a_treatment, a_tpids,
               b_order, b_filter, b_treatment, b_tpids,
        input  ready
    );
    modport sink (
        input  valid, a_order, a_filter, a_treatment, a_tpids,
               b_order, b_filter, b_treatment, b_tpids,
        output ready
    );
endinterface

interface vrc_result_if;
    logic           valid;
    logic           ready;
    vrc_pkg::ord_t  order_result;

    modport source (
        output valid, order_result,
        input  ready
    );
    modport sink (
        input  valid, order_result,
        output ready
    );
endinterface

// ===== hw/rtl/vlan_rule_order_compare.sv =====
// Channel   Dir   Payload
// rules     in    a/b order, filter, treatment, tpids
// result    out   order_result (-1 before, 0 equal, 1 after)
//
// One rule pair per cycle unless the result stalls; each pair passes an input register, then a result register.
// The compare chain between the two registers is the only logic stage.
// rst_n clears both valid flags asynchronously; payload registers hold no reset.
// A stalled result holds; rules.ready is high while the input stage is empty or the result stage is free.

`include "vlan_rule_order_compare_macros.svh"

module vlan_rule_order_compare #(
    parameter int SORT_PRIORITY_BITS = 8,
    parameter int FILTER_INDEX_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    vrc_rule_if.sink          rules,
    vrc_result_if.source      result
);

    localparam int OW = vrc_pkg::ORDER_W;

    // Larger value sorts later
    function automatic vrc_pkg::ord_t cmp_up(input logic [15:0] a, input logic [15:0] b);
        if (a == b)
            return vrc_pkg::ORD_EQUAL;
        return (a < b) ? vrc_pkg::ORD_BEFORE : vrc_pkg::ORD_AFTER;
    endfunction

    function automatic logic is_default(input logic [vrc_pkg::FILTER_W-1:0] f);
        logic [3:0] op;
        logic [3:0] ip;
        op = f[47:44];
        ip = f[26:23];
        if (f[5:2] != vrc_pkg::ET_IGNORE)
            return 1'b0;
        return (op == vrc_pkg::PRI_15 && ip == vrc_pkg::PRI_15) ||
               (op == vrc_pkg::PRI_15 && ip == vrc_pkg::PRI_14) ||
               (op == vrc_pkg::PRI_14 && ip == vrc_pkg::PRI_14);
    endfunction

    // tag: pri [20:17], vid [16:4], tpid/de [3:0]
    function automatic vrc_pkg::ord_t cmp_tag(
        input logic [20:0] ta,
        input logic [20:0] tb,
        input logic        filt,
        input logic [15:0] ina,
        input logic [15:0] inb,
        input logic [15:0] outa,
        input logic [15:0] outb
    );
        vrc_pkg::ord_t r;
        logic [3:0]    ca;
        logic [3:0]    cb;
        logic          sel_in;
        logic          sel_out;
        ca = ta[3:0];
        cb = tb[3:0];
        r = cmp_up(16'(ta[20:17]), 16'(tb[20:17]));
        if (r != vrc_pkg::ORD_EQUAL)
            return r;
        r = cmp_up(16'(ta[16:4]), 16'(tb[16:4]));
        if (r != vrc_pkg::ORD_EQUAL)
            return r;
        if (ca != cb)
        begin
            // filter codes: larger sorts first; treatment codes: larger sorts later
            if (filt)
                return (ca < cb) ? vrc_pkg::ORD_AFTER : vrc_pkg::ORD_BEFORE;
            return (ca < cb) ? vrc_pkg::ORD_BEFORE : vrc_pkg::ORD_AFTER;
        end
        if (filt)
        begin
            sel_in  = (ca == vrc_pkg::TDE_0101) || (ca == vrc_pkg::TDE_0110) ||
                      (ca == vrc_pkg::TDE_0111);
            sel_out = (ca == vrc_pkg::TDE_1000) || (ca == vrc_pkg::TDE_1001) ||
                      (ca == vrc_pkg::TDE_1010);
        end
        else
        begin
            sel_in  = (ca == vrc_pkg::TDE_1000) || (ca == vrc_pkg::TDE_1001);
            sel_out = (ca == vrc_pkg::TDE_0010) || (ca == vrc_pkg::TDE_0011) ||
                      (ca == vrc_pkg::TDE_0110) || (ca == vrc_pkg::TDE_0111);
        end
        if (sel_in)
            return cmp_up(ina, inb);
        if (sel_out)
            return cmp_up(outa, outb);
        return vrc_pkg::ORD_EQUAL;
    endfunction

    // Input stage
    logic                           s1_valid_reg;
    logic [OW-1:0]                  a_order_reg;
    logic [vrc_pkg::FILTER_W-1:0]   a_filter_reg;
    logic [vrc_pkg::TREAT_W-1:0]    a_treat_reg;
    logic [vrc_pkg::TPIDS_W-1:0]    a_tpids_reg;
    logic [OW-1:0]                  b_order_reg;
    logic [vrc_pkg::FILTER_W-1:0]   b_filter_reg;
    logic [vrc_pkg::TREAT_W-1:0]    b_treat_reg;
    logic [vrc_pkg::TPIDS_W-1:0]    b_tpids_reg;

    // Result stage
    logic                           out_valid_reg;
    vrc_pkg::ord_t                  result_reg;
    vrc_pkg::ord_t                  result_next;

    logic                           out_free;
    logic                           s1_free;
    logic                           s1_adv;

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign s1_free     = !s1_valid_reg || out_free;
    assign rules.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= rules.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rules.valid && s1_free)
        begin
            a_order_reg  <= rules.a_order;
            a_filter_reg <= rules.a_filter;
            a_treat_reg  <= rules.a_treatment;
            a_tpids_reg  <= rules.a_tpids;
            b_order_reg  <= rules.b_order;
            b_filter_reg <= rules.b_filter;
            b_treat_reg  <= rules.b_treatment;
            b_tpids_reg  <= rules.b_tpids;
        end
        if (s1_adv)
            result_reg <= result_next;
    end

    // Sort priority sits above the filter index; bits past the word read as zero
    logic [2*OW-1:0]                a_ord_ext;
    logic [2*OW-1:0]                b_ord_ext;
    logic [SORT_PRIORITY_BITS-1:0]  sa;
    logic [SORT_PRIORITY_BITS-1:0]  sb;
    logic [FILTER_INDEX_BITS-1:0]   ia;
    logic [FILTER_INDEX_BITS-1:0]   ib;
    logic                           da;
    logic                           db;
    vrc_pkg::ord_t                  r_idx;
    vrc_pkg::ord_t                  r_fo;
    vrc_pkg::ord_t                  r_fi;
    vrc_pkg::ord_t                  r_ttr;
    vrc_pkg::ord_t                  r_to;
    vrc_pkg::ord_t                  r_ti;
    logic [3:0]                     ea;
    logic [3:0]                     eb;

    assign a_ord_ext = {{OW{1'b0}}, a_order_reg} >> FILTER_INDEX_BITS;
    assign b_ord_ext = {{OW{1'b0}}, b_order_reg} >> FILTER_INDEX_BITS;
    assign sa = a_ord_ext[SORT_PRIORITY_BITS-1:0];
    assign sb = b_ord_ext[SORT_PRIORITY_BITS-1:0];
    assign ia = a_order_reg[FILTER_INDEX_BITS-1:0];
    assign ib = b_order_reg[FILTER_INDEX_BITS-1:0];
    assign da = is_default(a_filter_reg);
    assign db = is_default(b_filter_reg);
    assign ea = a_filter_reg[5:2];
    assign eb = b_filter_reg[5:2];

    assign r_idx = cmp_up(16'(ia), 16'(ib));
    assign r_fo  = cmp_tag(a_filter_reg[47:27], b_filter_reg[47:27], 1'b1,
                           a_tpids_reg[31:16], b_tpids_reg[31:16],
                           a_tpids_reg[15:0], b_tpids_reg[15:0]);
    assign r_fi  = cmp_tag(a_filter_reg[26:6], b_filter_reg[26:6], 1'b1,
                           a_tpids_reg[31:16], b_tpids_reg[31:16],
                           a_tpids_reg[15:0], b_tpids_reg[15:0]);
    assign r_ttr = cmp_up(16'(a_filter_reg[1:0]), 16'(b_filter_reg[1:0]));
    assign r_to  = cmp_tag(a_treat_reg[41:21], b_treat_reg[41:21], 1'b0,
                           a_tpids_reg[31:16], b_tpids_reg[31:16],
                           a_tpids_reg[15:0], b_tpids_reg[15:0]);
    assign r_ti  = cmp_tag(a_treat_reg[20:0], b_treat_reg[20:0], 1'b0,
                           a_tpids_reg[31:16], b_tpids_reg[31:16],
                           a_tpids_reg[15:0], b_tpids_reg[15:0]);

    // First deciding field wins
    always_comb
    begin
        if (sa != sb)
            result_next = (sa > sb) ? vrc_pkg::ORD_BEFORE : vrc_pkg::ORD_AFTER;
        else if (r_idx != vrc_pkg::ORD_EQUAL)
            result_next = r_idx;
        else if (da != db)
            result_next = da ? vrc_pkg::ORD_AFTER : vrc_pkg::ORD_BEFORE;
        else if (r_fo != vrc_pkg::ORD_EQUAL)
            result_next = r_fo;
        else if (r_fi != vrc_pkg::ORD_EQUAL)
            result_next = r_fi;
        else if (ea != eb)
            result_next = (ea < eb) ? vrc_pkg::ORD_AFTER : vrc_pkg::ORD_BEFORE;
        else if (r_ttr != vrc_pkg::ORD_EQUAL)
            result_next = r_ttr;
        else if (r_to != vrc_pkg::ORD_EQUAL)
            result_next = r_to;
        else
            result_next = r_ti;
    end

    assign result.valid        = out_valid_reg;
    assign result.order_result = result_reg;

    `VRC_ASSERT_NOW(a_code_legal, clk, rst_n, out_valid_reg, result_reg != 2'sb10)
    `VRC_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_adv, out_valid_reg)
    `VRC_ASSERT_NOW(a_self_equal, clk, rst_n,
        s1_valid_reg && a_order_reg == b_order_reg && a_filter_reg == b_filter_reg &&
        a_treat_reg == b_treat_reg && a_tpids_reg == b_tpids_reg,
        result_next == vrc_pkg::ORD_EQUAL)

endmodule
